@@ rtl/nwpf_pkg.sv @@
// Package for the nibble wildcard pattern finder.
// Holds register index codes and fixed field widths; no dependencies.
package nwpf_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned OFFSET_W   = 32;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned LEN_W      = 5;
	localparam int unsigned MASK_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET  = 3'd4;

	localparam logic [LEN_W-1:0] PATTERN_LEN_RESET = 5'd1;

endpackage

@@ rtl/nwpf_in_if.sv @@
// Input channel of the pattern finder: one stream byte per transaction.
// Depends on nwpf_pkg only for style consistency with the other channel.
interface nwpf_in_if import nwpf_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/nwpf_out_if.sv @@
// Result channel of the pattern finder: found flag and match offset.
// Uses OFFSET_W from nwpf_pkg.
interface nwpf_out_if import nwpf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                found;
	logic [OFFSET_W-1:0] match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink   (input valid, input found, input match_offset, output ready);
endinterface

@@ rtl/nibble_wildcard_pattern_finder.sv @@
// Nibble wildcard pattern finder: an accepted byte passes through the input stage register
// and then the result register. Throughput is one byte per cycle; the compare of every pattern
// position against the window is combinational logic between those two registers.
// The input stalls only while the result register holds a result that is not taken.
// Reset (arst_n low) empties both stages, clears window, count and match flag,
// and returns the configuration registers to their defaults (length 1, others 0).
module nibble_wildcard_pattern_finder import nwpf_pkg::*; #(
	parameter int unsigned MAX_PATTERN_BYTES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	nwpf_in_if.sink               byte_in,
	nwpf_out_if.source            result
);

	localparam int unsigned IW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	// Configuration registers.
	logic [63:0]         pat_lo_q;
	logic [63:0]         pat_hi_q;
	logic [MASK_W-1:0]   care_q;
	logic [LEN_W-1:0]    plen_q;
	logic [OFFSET_W-1:0] base_q;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Stream state.
	logic [7:0]         window_q [MAX_PATTERN_BYTES];
	logic [COUNT_W-1:0] count_q;
	logic               reported_q;

	// Result register.
	logic                out_valid_q;
	logic                out_found_q;
	logic [OFFSET_W-1:0] out_offset_q;

	logic [7:0]          win_nx [MAX_PATTERN_BYTES];
	logic [COUNT_W-1:0]  count_nx;
	logic [LEN_W-1:0]    len_eff;
	logic [127:0]        pattern;
	logic                window_hit;
	logic                hit;
	logic                emit;
	logic                out_free;
	logic                advance;
	logic [OFFSET_W-1:0] hit_offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '0;
			plen_q   <= PATTERN_LEN_RESET;
			base_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PATTERN_LOW:  pat_lo_q <= cfg_wdata;
				REG_PATTERN_HIGH: pat_hi_q <= cfg_wdata;
				REG_CARE_MASK:    care_q   <= cfg_wdata[MASK_W-1:0];
				REG_PATTERN_LEN:  plen_q   <= cfg_wdata[LEN_W-1:0];
				REG_BASE_OFFSET:  base_q   <= cfg_wdata[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free     = !out_valid_q || result.ready;
	assign advance      = valid_s1 && out_free;
	assign byte_in.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.last_byte;
		end
	end

	always_comb begin
		win_nx[0] = byte_s1;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
			win_nx[k] = window_q[k-1];
		end
	end

	assign count_nx = (count_q == '1) ? count_q : count_q + COUNT_W'(1);

	always_comb begin
		if (plen_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (plen_q > LEN_W'(MAX_PATTERN_BYTES)) begin
			len_eff = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len_eff = plen_q;
		end
	end

	assign pattern = {pat_hi_q, pat_lo_q};

	// Pattern byte j lines up with the window entry len-1-j, oldest byte first.
	always_comb begin
		logic [LEN_W-1:0] idx;
		logic [7:0]       have;
		logic [7:0]       want;
		window_hit = 1'b1;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			idx  = len_eff - LEN_W'(j) - LEN_W'(1);
			have = win_nx[idx[IW-1:0]];
			want = pattern[8*j +: 8];
			if (LEN_W'(j) < len_eff) begin
				if (care_q[2*j] && (have[3:0] != want[3:0])) begin
					window_hit = 1'b0;
				end
				if (care_q[2*j+1] && (have[7:4] != want[7:4])) begin
					window_hit = 1'b0;
				end
			end
		end
	end

	assign hit        = !reported_q && (count_nx >= COUNT_W'(len_eff)) && window_hit;
	assign emit       = hit || (last_s1 && !reported_q);
	assign hit_offset = base_q + (count_nx - COUNT_W'(len_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
				window_q[k] <= '0;
			end
			count_q    <= '0;
			reported_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
					window_q[k] <= '0;
				end
				count_q    <= '0;
				reported_q <= 1'b0;
			end else begin
				window_q   <= win_nx;
				count_q    <= count_nx;
				reported_q <= reported_q || hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_found_q  <= hit;
			out_offset_q <= hit ? hit_offset : '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.found        = out_found_q;
	assign result.match_offset = out_offset_q;

`ifndef ASSERT_OFF
	a_hit_sets_reported: assert property (@(posedge clk) disable iff (!arst_n)
		advance && hit && !last_s1 |=> reported_q)
		else $error("match flag not set after a found result");

	a_last_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> (count_q == '0) && !reported_q)
		else $error("stream state not cleared after the last byte");

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_in.ready |-> valid_s1 && out_valid_q && !result.ready)
		else $error("input stalled while the result register could take a result");

	a_not_found_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_found_q |-> out_offset_q == '0)
		else $error("not-found result carries a nonzero offset");
`endif

endmodule
